// ===== hw/rtl/lrca_pkg.sv =====
// ----------------------------------------------------------------------------
// lrca_pkg
// Shared constants for the LED ring chase and fade animator.
// ----------------------------------------------------------------------------
package lrca_pkg;

  localparam int MAX_COLORS_DEF = 64;
  localparam int RING_LEDS_DEF  = 18;

  localparam int COLOR_W   = 16;
  localparam int DIV_STEPS = 16;
  localparam int LANES     = 3;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_SAME = 2'd1;
  localparam logic [1:0] MODE_SPIN = 2'd2;
  localparam logic [1:0] MODE_FALL = 2'd3;

  localparam logic [1:0] REG_DEFAULT_MODE = 2'd0;
  localparam logic [1:0] REG_FRAME_STEPS  = 2'd1;
  localparam logic [1:0] REG_COLOR_COUNT  = 2'd2;

  localparam logic [1:0] DEFAULT_MODE_RST = MODE_SPIN;
  localparam logic [7:0] FRAME_STEPS_RST  = 8'd8;
  localparam logic [6:0] COLOR_COUNT_RST  = 7'd1;

  localparam logic [7:0] PAD_MAX          = 8'd191;
  localparam logic [7:0] LOOP_FOREVER     = 8'hFF;
  localparam logic [7:0] FALL_AUTO_PAD    = 8'd4;
  localparam logic [6:0] FALL_PAD_MIN_LEN = 7'd5;

endpackage

// ===== hw/rtl/lrca_if.sv =====
// ----------------------------------------------------------------------------
// lrca_cmd_if / lrca_led_if
// Valid/ready channels for command items and LED result items.
// ----------------------------------------------------------------------------
interface lrca_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [5:0] color_slot;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [1:0] mode_override;
  logic [7:0] loop_request;
  logic [7:0] pad_override;

  modport source(output valid, kind, color_slot, red_in, green_in, blue_in,
                 mode_override, loop_request, pad_override, input ready);
  modport sink(input valid, kind, color_slot, red_in, green_in, blue_in,
               mode_override, loop_request, pad_override, output ready);
endinterface

interface lrca_led_if;
  logic       valid;
  logic       ready;
  logic [4:0] led_pos;
  logic [6:0] red_out;
  logic [6:0] green_out;
  logic [6:0] blue_out;
  logic       last;
  logic       finished;

  modport source(output valid, led_pos, red_out, green_out, blue_out, last, finished,
                 input ready);
  modport sink(input valid, led_pos, red_out, green_out, blue_out, last, finished,
               output ready);
endinterface

// ===== hw/rtl/lrca_ram.sv =====
// ----------------------------------------------------------------------------
// lrca_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module lrca_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lrca_div.sv =====
// ----------------------------------------------------------------------------
// lrca_div
// Three-lane restoring divider, one quotient bit per cycle, 16-bit dividends
// over a shared 8-bit divisor.
// ----------------------------------------------------------------------------
module lrca_div (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            start,
  input  logic [lrca_pkg::LANES-1:0][lrca_pkg::COLOR_W-1:0] dividend,
  input  logic [7:0]                                      divisor,
  output logic                                            done,
  output logic [lrca_pkg::LANES-1:0][lrca_pkg::COLOR_W-1:0] quotient,
  output logic [7:0]                                      remainder
);

  localparam int CW = $clog2(lrca_pkg::DIV_STEPS);

  logic                                             busy;
  logic [CW-1:0]                                    cnt;
  logic [7:0]                                       dvs;
  logic [lrca_pkg::LANES-1:0][7:0]                  rem;
  logic [lrca_pkg::LANES-1:0][7:0]                  rem_next;
  logic [lrca_pkg::LANES-1:0][lrca_pkg::COLOR_W-1:0] quo_next;

  always_comb begin
    for (int l = 0; l < lrca_pkg::LANES; l++) begin
      logic [8:0] t;
      logic       ge;
      t  = {rem[l], quotient[l][lrca_pkg::COLOR_W-1]};
      ge = t >= {1'b0, dvs};
      rem_next[l] = ge ? 8'(t - {1'b0, dvs}) : t[7:0];
      quo_next[l] = {quotient[l][lrca_pkg::COLOR_W-2:0], ge};
    end
  end

  assign remainder = rem[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(lrca_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= quo_next;
      rem      <= rem_next;
    end
  end

endmodule

// ===== hw/rtl/led_ring_chase_fade_animator_top.sv =====
// ----------------------------------------------------------------------------
// led_ring_chase_fade_animator_top
// LED ring animator: colour table, frame staging, per-tick fades and output.
// ----------------------------------------------------------------------------
// Load item: written to the colour table while idle. Fading tick: an add per lit
// LED, then RING_LEDS outputs. Start item: frame modulo, then per lit LED a
// current and target read and write and a divide, then outputs. Frame-end tick:
// copy per lit LED, outputs, then unless finished modulo and target divides.
// One item at a time; ready is low while an item is in work.
// Synchronous reset: animation idle, state zero, registers at defaults.
module led_ring_chase_fade_animator_top #(
  parameter int MAX_COLORS = lrca_pkg::MAX_COLORS_DEF,
  parameter int RING_LEDS  = lrca_pkg::RING_LEDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lrca_cmd_if.sink    cmd,
  lrca_led_if.source  led,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW  = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int LW  = $clog2(RING_LEDS);
  localparam int LCW = $clog2(RING_LEDS + 1);
  localparam int CW  = lrca_pkg::COLOR_W;
  localparam int NL  = lrca_pkg::LANES;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MOD   = 4'd1;
  localparam logic [3:0] ST_MODW  = 4'd2;
  localparam logic [3:0] ST_RDCUR = 4'd3;
  localparam logic [3:0] ST_WRCUR = 4'd4;
  localparam logic [3:0] ST_RDTGT = 4'd5;
  localparam logic [3:0] ST_WRTGT = 4'd6;
  localparam logic [3:0] ST_DIVW  = 4'd7;
  localparam logic [3:0] ST_ADD   = 4'd8;
  localparam logic [3:0] ST_COPY  = 4'd9;
  localparam logic [3:0] ST_EMIT  = 4'd10;

  localparam logic [1:0] THEN_DONE = 2'd0;
  localparam logic [1:0] THEN_LOAD = 2'd1;
  localparam logic [1:0] THEN_FIN  = 2'd2;

  logic [1:0]  default_mode;
  logic [7:0]  frame_steps;
  logic [6:0]  color_count;

  logic [3:0]  state;
  logic [1:0]  active_mode;
  logic [7:0]  fade_tick;
  logic [7:0]  frame_position;
  logic [7:0]  loops_left;
  logic [7:0]  pad_length;
  logic [7:0]  padded_length;
  logic [LCW-1:0] lit_count;
  logic [LW-1:0]  idx;
  logic        is_start;
  logic        fin;
  logic [1:0]  emit_then;
  logic [7:0]  f_tgt;
  logic        off;
  logic [NL-1:0] neg;

  logic [CW-1:0] cur [RING_LEDS][NL];
  logic [CW-1:0] tgt [RING_LEDS][NL];
  logic [CW-1:0] dlt [RING_LEDS][NL];

  logic [6:0]  eff_len;
  logic [7:0]  eff_steps;
  logic        cfg_wr;
  logic        cmd_acc;
  logic        led_acc;
  logic [1:0]  start_mode;
  logic [7:0]  loops_dec;
  logic [LCW-1:0] start_lit;
  logic [7:0]  start_pad;
  logic [7:0]  spin_pad [MAX_COLORS + 1];
  logic [7:0]  tick_ft;
  logic [7:0]  tick_pos;
  logic        lit_end;
  logic        led_end;
  logic        mirror;
  logic [LW-1:0] src;

  logic [7:0]  f_sel;
  logic [9:0]  ci0;
  logic [9:0]  ci;
  logic        ci_ok;

  logic [23:0] ram_rdata;
  logic        ram_we;
  logic [NL-1:0][CW-1:0] stage_val;

  logic                 div_start;
  logic                 div_done;
  logic [NL-1:0][CW-1:0] div_in;
  logic [NL-1:0][CW-1:0] div_q;
  logic [7:0]           div_rem;
  logic [NL-1:0][16:0]  diff;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cmd_acc = cmd.valid && cmd.ready;
  assign led_acc = led.valid && led.ready;

  assign eff_len   = (color_count > 7'(MAX_COLORS)) ? 7'(MAX_COLORS) : color_count;
  assign eff_steps = (frame_steps == 8'd0) ? 8'd1 : frame_steps;

  always_comb begin
    unique case (paddr[3:2])
      lrca_pkg::REG_DEFAULT_MODE: prdata = {30'd0, default_mode};
      lrca_pkg::REG_FRAME_STEPS:  prdata = {24'd0, frame_steps};
      lrca_pkg::REG_COLOR_COUNT:  prdata = {25'd0, color_count};
      default:                    prdata = 32'd0;
    endcase
  end

  // Start item decoding.
  assign start_mode = (cmd.mode_override != lrca_pkg::MODE_IDLE) ? cmd.mode_override
                                                                : default_mode;
  assign loops_dec = (cmd.loop_request != 8'd0 && cmd.loop_request != lrca_pkg::LOOP_FOREVER)
                     ? cmd.loop_request - 8'd1 : cmd.loop_request;

  // Automatic spin pad for every possible table length.
  for (genvar k = 0; k <= MAX_COLORS; k++) begin : g_spin_pad
    assign spin_pad[k] = 8'(RING_LEDS - k % RING_LEDS);
  end

  always_comb begin
    case (start_mode)
      lrca_pkg::MODE_SAME: start_lit = LCW'(1);
      lrca_pkg::MODE_SPIN: start_lit = LCW'(RING_LEDS);
      default:             start_lit = LCW'(RING_LEDS / 2);
    endcase
    if (cmd.pad_override != 8'd0) begin
      start_pad = (cmd.pad_override > lrca_pkg::PAD_MAX) ? lrca_pkg::PAD_MAX
                                                         : cmd.pad_override;
    end else if (start_mode == lrca_pkg::MODE_SAME) begin
      start_pad = 8'd1;
    end else if (start_mode == lrca_pkg::MODE_SPIN) begin
      start_pad = spin_pad[eff_len];
    end else if (eff_len >= lrca_pkg::FALL_PAD_MIN_LEN) begin
      start_pad = lrca_pkg::FALL_AUTO_PAD;
    end else begin
      start_pad = (8'(start_lit) > 8'(eff_len)) ? 8'(start_lit) - 8'(eff_len) : 8'd1;
    end
  end

  assign tick_ft  = fade_tick + 8'd1;
  assign tick_pos = frame_position + 8'd1;
  assign lit_end  = (LCW'(idx) + LCW'(1)) == lit_count;
  assign led_end  = idx == LW'(RING_LEDS - 1);

  // Output LED source: same mode shows LED 0, fall mode mirrors the lower half.
  assign mirror = (active_mode == lrca_pkg::MODE_FALL) &&
                  (32'(idx) >= 32'(RING_LEDS - RING_LEDS / 2));
  assign src = (active_mode == lrca_pkg::MODE_SAME) ? '0 :
               mirror ? LW'(RING_LEDS - 1) - idx : idx;

  assign led.valid      = state == ST_EMIT;
  assign led.led_pos    = 5'(idx);
  assign led.red_out    = cur[src][0][14:8];
  assign led.green_out  = cur[src][1][14:8];
  assign led.blue_out   = cur[src][2][14:8];
  assign led.last       = led_end;
  assign led.finished   = fin;
  assign cmd.ready      = state == ST_IDLE;

  // Colour table index for the staged frame and LED.
  assign f_sel = (state == ST_RDCUR) ? padded_length - 8'd1 : f_tgt;
  assign ci0   = {2'b00, f_sel} - 10'(idx);
  assign ci    = ci0[9] ? ci0 + {2'b00, padded_length} : ci0;
  assign ci_ok = (padded_length != 8'd0) && !ci[9] && (ci < 10'(eff_len));

  assign ram_we = cmd_acc && (cmd.kind == lrca_pkg::KIND_LOAD) &&
                  ({1'b0, cmd.color_slot} < 7'(MAX_COLORS));

  lrca_ram #(.WIDTH(24), .DEPTH(MAX_COLORS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.color_slot[AW-1:0]),
    .wdata ({cmd.red_in, cmd.green_in, cmd.blue_in}),
    .raddr (ci[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int c = 0; c < NL; c++) begin
      stage_val[c] = off ? '0 : {1'b0, ram_rdata[8*(NL-1-c) +: 8], 7'd0};
      diff[c]      = {1'b0, stage_val[c]} - {1'b0, cur[idx][c]};
    end
    div_start = (state == ST_MOD) || (state == ST_WRTGT);
    if (state == ST_MOD) begin
      div_in = '0;
      div_in[0] = CW'(tick_pos);
    end else begin
      for (int c = 0; c < NL; c++) begin
        div_in[c] = diff[c][16] ? CW'(-diff[c]) : diff[c][CW-1:0];
      end
    end
  end

  lrca_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_in),
    .divisor   ((state == ST_MOD) ? padded_length : eff_steps),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      default_mode <= lrca_pkg::DEFAULT_MODE_RST;
      frame_steps  <= lrca_pkg::FRAME_STEPS_RST;
      color_count  <= lrca_pkg::COLOR_COUNT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        lrca_pkg::REG_DEFAULT_MODE: default_mode <= pwdata[1:0];
        lrca_pkg::REG_FRAME_STEPS:  frame_steps  <= pwdata[7:0];
        lrca_pkg::REG_COLOR_COUNT:  color_count  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      active_mode    <= lrca_pkg::MODE_IDLE;
      fade_tick      <= '0;
      frame_position <= '0;
      loops_left     <= '0;
      pad_length     <= '0;
      padded_length  <= '0;
      lit_count      <= '0;
      idx            <= '0;
      is_start       <= 1'b0;
      fin            <= 1'b0;
      emit_then      <= THEN_DONE;
      f_tgt          <= '0;
      off            <= 1'b0;
      neg            <= '0;
      for (int i = 0; i < RING_LEDS; i++) begin
        for (int c = 0; c < NL; c++) begin
          cur[i][c] <= '0;
          tgt[i][c] <= '0;
          dlt[i][c] <= '0;
        end
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_acc && cmd.kind == lrca_pkg::KIND_START) begin
            active_mode <= start_mode;
            if (start_mode != lrca_pkg::MODE_IDLE) begin
              fade_tick      <= '0;
              frame_position <= '0;
              loops_left     <= loops_dec;
              lit_count      <= start_lit;
              pad_length     <= start_pad;
              padded_length  <= 8'(eff_len) + 8'(start_lit);
              is_start       <= 1'b1;
              state          <= ST_MOD;
            end
          end else if (cmd_acc && cmd.kind == lrca_pkg::KIND_TICK &&
                       active_mode != lrca_pkg::MODE_IDLE) begin
            is_start <= 1'b0;
            idx      <= '0;
            if (tick_ft < eff_steps) begin
              fade_tick <= tick_ft;
              state     <= ST_ADD;
            end else begin
              fade_tick      <= '0;
              frame_position <= tick_pos;
              if (pad_length != 8'd0 && tick_pos == 8'(eff_len)) begin
                padded_length <= 8'(eff_len) +
                                 ((loops_left != 8'd0) ? pad_length : 8'(lit_count));
              end
              state <= ST_COPY;
            end
          end
        end
        ST_MOD: state <= ST_MODW;
        ST_MODW: begin
          if (div_done) begin
            f_tgt <= (div_rem == 8'd0) ? padded_length - 8'd1 : div_rem - 8'd1;
            idx   <= '0;
            state <= is_start ? ST_RDCUR : ST_RDTGT;
          end
        end
        ST_RDCUR: begin
          off   <= !ci_ok;
          state <= ST_WRCUR;
        end
        ST_WRCUR: begin
          for (int c = 0; c < NL; c++) cur[idx][c] <= stage_val[c];
          state <= ST_RDTGT;
        end
        ST_RDTGT: begin
          off   <= !ci_ok;
          state <= ST_WRTGT;
        end
        ST_WRTGT: begin
          for (int c = 0; c < NL; c++) begin
            tgt[idx][c] <= stage_val[c];
            neg[c]      <= diff[c][16];
          end
          state <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_done) begin
            for (int c = 0; c < NL; c++) begin
              dlt[idx][c] <= neg[c] ? CW'(-div_q[c]) : div_q[c];
            end
            if (lit_end) begin
              idx       <= '0;
              fin       <= 1'b0;
              emit_then <= THEN_DONE;
              state     <= is_start ? ST_EMIT : ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= is_start ? ST_RDCUR : ST_RDTGT;
            end
          end
        end
        ST_ADD: begin
          for (int c = 0; c < NL; c++) cur[idx][c] <= cur[idx][c] + dlt[idx][c];
          if (lit_end) begin
            idx       <= '0;
            fin       <= 1'b0;
            emit_then <= THEN_DONE;
            state     <= ST_EMIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_COPY: begin
          for (int c = 0; c < NL; c++) cur[idx][c] <= tgt[idx][c];
          if (lit_end) begin
            idx <= '0;
            if (frame_position == padded_length && loops_left == 8'd0) begin
              fin       <= 1'b1;
              emit_then <= THEN_FIN;
            end else begin
              fin       <= 1'b0;
              emit_then <= THEN_LOAD;
            end
            state <= ST_EMIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_EMIT: begin
          if (led_acc) begin
            if (mirror) begin
              for (int c = 0; c < NL; c++) cur[idx][c] <= cur[src][c];
            end
            if (led_end) begin
              idx <= '0;
              case (emit_then)
                THEN_FIN: begin
                  active_mode <= lrca_pkg::MODE_IDLE;
                  state       <= ST_IDLE;
                end
                THEN_LOAD: begin
                  if (frame_position == padded_length) begin
                    if (loops_left != lrca_pkg::LOOP_FOREVER) begin
                      loops_left <= loops_left - 8'd1;
                    end
                    frame_position <= '0;
                  end
                  state <= ST_MOD;
                end
                default: state <= ST_IDLE;
              endcase
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
